>>> hw/rtl/nrl_pkg.sv
// ----------------------------------------------------------------------------
// nrl_pkg: shared types for the run-list VCN lookup
// Field widths, status codes, decoder phases and the item/result records.
// ----------------------------------------------------------------------------
package nrl_pkg;

	localparam int FIELD_W = 48;   // width of every VCN/LCN field on the ports
	localparam int BYTE_W  = 8;

	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,   // target located
		ST_RANGE = 2'd1,   // target outside low..high
		ST_END   = 2'd2    // terminator reached without a match
	} status_t;

	typedef enum logic [2:0] {
		PH_DONE   = 3'b001,
		PH_HEADER = 3'b010,
		PH_BODY   = 3'b100
	} phase_t;

	typedef struct packed {
		logic [FIELD_W-1:0] high_vcn;
		logic [FIELD_W-1:0] low_vcn;
		logic [FIELD_W-1:0] target_vcn;
		logic               list_start;
		logic [BYTE_W-1:0]  run_byte;
	} item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] run_count;
		logic [FIELD_W-1:0] lcn;
		status_t            status;
	} result_t;

endpackage

>>> hw/rtl/nrl_decode.sv
// ----------------------------------------------------------------------------
// nrl_decode: run-list decoder state and per-byte step
// Holds the list state and works out the next state and result for one byte.
// ----------------------------------------------------------------------------
module nrl_decode #(
	parameter int CLUSTER_BITS = 48
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  nrl_pkg::item_t  item,
	output logic            res_valid,
	output nrl_pkg::result_t res
);

	localparam int CW = CLUSTER_BITS;
	localparam int NB = (CW + 7) / 8;
	localparam int AW = NB * 8;

	nrl_pkg::phase_t phase_q, phase_d;
	logic [3:0]    count_len_q, count_len_d;
	logic [3:0]    offset_len_q, offset_len_d;
	logic [4:0]    byte_pos_q, byte_pos_d;
	logic [CW-1:0] count_acc_q, count_acc_d;
	logic [CW-1:0] offset_acc_q, offset_acc_d;
	logic [CW-1:0] running_lcn_q, running_lcn_d;
	logic [CW-1:0] base_vcn_q, base_vcn_d;
	logic [CW-1:0] wanted_vcn_q, wanted_vcn_d;
	logic [CW-1:0] vcn_dist;   // wanted - base
	logic          vcn_ge;     // base <= wanted

	logic [CW-1:0] tgt, lo, hi;
	logic [7:0]    b;
	logic [4:0]    k;
	logic          in_count, last_off, run_end, hit;
	logic [AW-1:0] cnt_w, off_w;
	logic [CW-1:0] count_mrg, offset_mrg, lcn_new, found_lcn, remain;

	assign tgt = CW'(item.target_vcn);
	assign lo  = CW'(item.low_vcn);
	assign hi  = CW'(item.high_vcn);
	assign b   = item.run_byte;

	// Merge the current body byte into the count or delta field
	always_comb begin
		k        = byte_pos_q - {1'b0, count_len_q};
		in_count = byte_pos_q < {1'b0, count_len_q};
		last_off = (k + 5'd1) == {1'b0, offset_len_q};
		cnt_w    = AW'(count_acc_q);
		off_w    = AW'(offset_acc_q);
		for (int i = 0; i < NB; i++) begin
			if (in_count && byte_pos_q == 5'(i)) begin
				cnt_w[i*8 +: 8] = b;
			end
			if (!in_count && k == 5'(i)) begin
				off_w[i*8 +: 8] = b;
			end
			// sign-extend from the top delta byte
			if (!in_count && last_off && b[7] && (5'(i) >= {1'b0, offset_len_q})) begin
				off_w[i*8 +: 8] = 8'hff;
			end
		end
		count_mrg  = CW'(cnt_w);
		offset_mrg = CW'(off_w);
	end

	assign vcn_dist  = wanted_vcn_q - base_vcn_q;
	assign vcn_ge    = base_vcn_q <= wanted_vcn_q;
	assign run_end   = ({1'b0, byte_pos_q} + 6'd1) >= ({2'b0, count_len_q} + {2'b0, offset_len_q});
	assign lcn_new   = running_lcn_q + offset_mrg;
	assign hit       = vcn_ge && (vcn_dist < count_mrg);
	assign remain    = count_mrg - vcn_dist;
	assign found_lcn = (offset_mrg == '0) ? '0 : running_lcn_q + offset_mrg + vcn_dist;

	always_comb begin
		phase_d       = phase_q;
		count_len_d   = count_len_q;
		offset_len_d  = offset_len_q;
		byte_pos_d    = byte_pos_q;
		count_acc_d   = count_acc_q;
		offset_acc_d  = offset_acc_q;
		running_lcn_d = running_lcn_q;
		base_vcn_d    = base_vcn_q;
		wanted_vcn_d  = wanted_vcn_q;
		res_valid     = 1'b0;
		res.status    = nrl_pkg::ST_FOUND;
		res.lcn       = '0;
		res.run_count = '0;

		if (item.list_start) begin
			wanted_vcn_d  = tgt;
			base_vcn_d    = lo;
			running_lcn_d = '0;
			count_len_d   = '0;
			offset_len_d  = '0;
			byte_pos_d    = '0;
			count_acc_d   = '0;
			offset_acc_d  = '0;
			if (tgt < lo || tgt > hi) begin
				phase_d    = nrl_pkg::PH_DONE;
				res_valid  = 1'b1;
				res.status = nrl_pkg::ST_RANGE;
			end else if (b == 8'h00) begin
				phase_d    = nrl_pkg::PH_DONE;
				res_valid  = 1'b1;
				res.status = nrl_pkg::ST_END;
			end else begin
				count_len_d  = b[3:0];
				offset_len_d = b[7:4];
				phase_d      = nrl_pkg::PH_BODY;
			end
		end else begin
			unique case (phase_q)
				nrl_pkg::PH_DONE: begin
				end
				nrl_pkg::PH_HEADER: begin
					if (b == 8'h00) begin
						phase_d    = nrl_pkg::PH_DONE;
						res_valid  = 1'b1;
						res.status = nrl_pkg::ST_END;
					end else begin
						count_len_d  = b[3:0];
						offset_len_d = b[7:4];
						byte_pos_d   = '0;
						count_acc_d  = '0;
						offset_acc_d = '0;
						phase_d      = nrl_pkg::PH_BODY;
					end
				end
				nrl_pkg::PH_BODY: begin
					count_acc_d  = count_mrg;
					offset_acc_d = offset_mrg;
					byte_pos_d   = byte_pos_q + 5'd1;
					if (run_end) begin
						running_lcn_d = lcn_new;
						phase_d       = nrl_pkg::PH_HEADER;
						if (hit) begin
							phase_d       = nrl_pkg::PH_DONE;
							res_valid     = 1'b1;
							res.status    = nrl_pkg::ST_FOUND;
							res.lcn       = nrl_pkg::FIELD_W'(found_lcn);
							res.run_count = nrl_pkg::FIELD_W'(remain);
						end else begin
							base_vcn_d = base_vcn_q + count_mrg;
						end
					end
				end
				default: begin
					phase_d = nrl_pkg::PH_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= nrl_pkg::PH_DONE;
			count_len_q   <= '0;
			offset_len_q  <= '0;
			byte_pos_q    <= '0;
			count_acc_q   <= '0;
			offset_acc_q  <= '0;
			running_lcn_q <= '0;
			base_vcn_q    <= '0;
			wanted_vcn_q  <= '0;
		end else if (en) begin
			phase_q       <= phase_d;
			count_len_q   <= count_len_d;
			offset_len_q  <= offset_len_d;
			byte_pos_q    <= byte_pos_d;
			count_acc_q   <= count_acc_d;
			offset_acc_q  <= offset_acc_d;
			running_lcn_q <= running_lcn_d;
			base_vcn_q    <= base_vcn_d;
			wanted_vcn_q  <= wanted_vcn_d;
		end
	end

endmodule

>>> hw/rtl/ntfs_run_list_vcn_lookup.sv
// ----------------------------------------------------------------------------
// ntfs_run_list_vcn_lookup: NTFS data run-list decoder with VCN lookup
// Streams a run list one byte per word and reports where a target VCN lives.
// ----------------------------------------------------------------------------
// One run-list byte is taken per clock while the output side keeps up: each
// word is held in an input register, decoded by a single step of header,
// shift-in or add-and-compare logic, and any result lands in an output
// register, so a result word follows its byte through the input and output
// registers, and a stalled output side holds back the input. Mark the first
// byte of a list with s_tuser; target_vcn, low_vcn and high_vcn are sampled
// only on that word. Each list yields at most one result word: found (lcn, or
// 0 for a sparse run, and the clusters left in the run), target out of range,
// or terminator reached. Bytes after that result are dropped until the next
// list start; a new list start abandons any list in progress. Cluster
// arithmetic wraps at CLUSTER_BITS bits, and results are carried on 48-bit
// fields. There is no memory and no clearing pass after reset.
// ----------------------------------------------------------------------------
module ntfs_run_list_vcn_lookup #(
	parameter int CLUSTER_BITS = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [151:0] s_tdata,   // run_byte[7:0], target_vcn[55:8],
	                                // low_vcn[103:56], high_vcn[151:104]
	input  logic         s_tuser,   // list_start
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata    // status[1:0], lcn[49:2], run_count[97:50],
	                                // zero fill [103:98]
);

	nrl_pkg::item_t   item_s1;
	logic             valid_s1;
	logic             advance;
	logic             res_valid;
	nrl_pkg::result_t res;
	nrl_pkg::result_t out_q;
	logic             out_valid_q;

	// Step the decoder whenever a byte is waiting and the output register is
	// free or draining this cycle.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register: hold the word until the decoder takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.run_byte   <= s_tdata[7:0];
			item_s1.target_vcn <= s_tdata[55:8];
			item_s1.low_vcn    <= s_tdata[103:56];
			item_s1.high_vcn   <= s_tdata[151:104];
			item_s1.list_start <= s_tuser;
		end
	end

	nrl_decode #(
		.CLUSTER_BITS(CLUSTER_BITS)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register: load on a decode step, drop once the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q.run_count, out_q.lcn, out_q.status};

endmodule

>>> bench/tb_ntfs_run_list_vcn_lookup.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ntfs_run_list_vcn_lookup: self-checking bench for the run-list VCN lookup
// Drives a short table of hand-built run lists, then about 800 words of
// random lists, plus noise. Every taken word also goes through a local
// decoder, and each result word is compared field by field with its prediction
// or a typed row result. Both stream sides idle at random except near the end.
// ----------------------------------------------------------------------------
module tb_ntfs_run_list_vcn_lookup;
	import nrl_pkg::*;

	localparam int          RANDOM_WORDS = 800;
	localparam int          CYCLE_LIMIT  = 200000;
	localparam logic [47:0] VCN_MAX      = '1;

	// where the expected result of a stimulus word comes from
	typedef enum logic [1:0] {
		CHK_MODEL,   // local decoder
		CHK_NONE,    // typed in: no result
		CHK_TYPED    // typed in: the result held in the row
	} chk_e;

	typedef struct packed {
		item_t   word;
		chk_e    chk;
		result_t typed;
	} stim_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [151:0] s_tdata;   // run_byte, target_vcn, low_vcn, high_vcn
	logic         s_tuser;   // list_start
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;   // status, lcn, run_count, zero fill

	stim_t   word_now;
	bit      idle_on;
	int      list_words = 0;
	int      miss_count = 0;
	int      cycles     = 0;
	result_t lookups_due[$];

	// local copy of the decoder state
	phase_t      dec_phase = PH_DONE;
	logic [3:0]  cnt_len   = '0;
	logic [3:0]  off_len   = '0;
	logic [4:0]  body_pos  = '0;
	logic [47:0] cnt_acc   = '0;
	logic [47:0] off_acc   = '0;
	logic [47:0] lcn_run   = '0;
	logic [47:0] vcn_base  = '0;
	logic [47:0] vcn_want  = '0;

	ntfs_run_list_vcn_lookup dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [47:0] rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[47:0];
	endfunction

	// mostly one-byte fields, now and then empty, long or beyond 48 bits
	function automatic int field_len();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return 0;
		if (pick <= 10)
			return 1;
		if (pick <= 13)
			return 2;
		if (pick == 14)
			return $urandom_range(3, 8);
		return $urandom_range(9, 15);
	endfunction

	function automatic stim_t row(input logic [7:0] b, input logic start,
			input logic [47:0] tgt, input logic [47:0] lo, input logic [47:0] hi,
			input chk_e chk, input status_t st, input logic [47:0] lcn,
			input logic [47:0] cnt);
		stim_t s;
		s.word.run_byte    = b;
		s.word.list_start  = start;
		s.word.target_vcn  = tgt;
		s.word.low_vcn     = lo;
		s.word.high_vcn    = hi;
		s.chk              = chk;
		s.typed.status     = st;
		s.typed.lcn        = lcn;
		s.typed.run_count  = cnt;
		return s;
	endfunction

	// A header byte: zero ends the list, otherwise its nibbles give the field lengths.
	function automatic bit take_header_byte(input logic [7:0] b, output result_t r);
		r = '0;
		if (b == 8'h00) begin
			r.status  = ST_END;
			dec_phase = PH_DONE;
			return 1'b1;
		end
		cnt_len   = b[3:0];
		off_len   = b[7:4];
		body_pos  = '0;
		cnt_acc   = '0;
		off_acc   = '0;
		dec_phase = PH_BODY;
		return 1'b0;
	endfunction

	// A count or delta byte; the last one of a run applies the delta and tests the target.
	function automatic bit take_body_byte(input logic [7:0] b, output result_t r);
		int          k;
		logic [47:0] span;
		r = '0;
		if (int'(body_pos) < int'(cnt_len)) begin
			// bytes at bit 48 and above fall off
			if (body_pos < 5'd6)
				cnt_acc |= 48'(b) << (8 * int'(body_pos));
		end else begin
			k = int'(body_pos) - int'(cnt_len);
			if (k < 6)
				off_acc |= 48'(b) << (8 * k);
			// sign-extend from the top delta byte; six or more bytes already fill the field
			if (k + 1 == int'(off_len) && b[7] && k + 1 < 6)
				off_acc |= VCN_MAX << (8 * (k + 1));
		end
		body_pos = body_pos + 5'd1;
		if (int'(body_pos) < int'(cnt_len) + int'(off_len))
			return 1'b0;
		lcn_run   = lcn_run + off_acc;
		span      = vcn_want - vcn_base;
		dec_phase = PH_HEADER;
		if (vcn_base <= vcn_want && span < cnt_acc) begin
			r.status    = ST_FOUND;
			r.lcn       = (off_acc == '0) ? '0 : lcn_run + span;   // zero delta: sparse
			r.run_count = cnt_acc - span;
			dec_phase   = PH_DONE;
			return 1'b1;
		end
		vcn_base = vcn_base + cnt_acc;
		return 1'b0;
	endfunction

	function automatic bit lookup_step(input item_t w, output result_t r);
		r = '0;
		if (w.list_start) begin
			// a list start abandons whatever was in progress
			vcn_want = w.target_vcn;
			vcn_base = w.low_vcn;
			lcn_run  = '0;
			cnt_len  = '0;
			off_len  = '0;
			body_pos = '0;
			cnt_acc  = '0;
			off_acc  = '0;
			if (w.target_vcn < w.low_vcn || w.target_vcn > w.high_vcn) begin
				r.status  = ST_RANGE;
				dec_phase = PH_DONE;
				return 1'b1;
			end
			return take_header_byte(w.run_byte, r);
		end
		if (dec_phase == PH_HEADER)
			return take_header_byte(w.run_byte, r);
		if (dec_phase == PH_BODY)
			return take_body_byte(w.run_byte, r);
		return 1'b0;
	endfunction

	task automatic log_miss(input string why, input result_t want, input result_t got);
		miss_count++;
		if (miss_count <= 10)
			$display("%0t %s: expected st=%0d lcn=%h cnt=%h, got st=%0d lcn=%h cnt=%h",
				$time, why, want.status, want.lcn, want.run_count,
				got.status, got.lcn, got.run_count);
	endtask

	// Present one word from a falling edge, hold it until taken, return at the next
	// falling edge. An idle burst may come first.
	task automatic send(input stim_t w);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		word_now = w;
		s_tvalid <= 1'b1;
		s_tuser  <= w.word.list_start;
		s_tdata  <= {w.word.high_vcn, w.word.low_vcn, w.word.target_vcn, w.word.run_byte};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Result side: stall in short random bursts while idling is on.
	initial begin
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Predict on every taken word; check every result word against the oldest one due.
	always @(posedge clk) begin : watch
		result_t seen;
		result_t want;
		result_t pred;
		bit      hit;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				hit = lookup_step(word_now.word, pred);
				if (word_now.chk == CHK_TYPED)
					lookups_due.push_back(word_now.typed);
				else if (word_now.chk == CHK_MODEL && hit)
					lookups_due.push_back(pred);
			end
			if (m_tvalid && m_tready) begin
				seen = result_t'(m_tdata[97:0]);
				if (lookups_due.size() == 0) begin
					log_miss("result with none due", '0, seen);
				end else begin
					want = lookups_due.pop_front();
					if (seen.status !== want.status || seen.lcn !== want.lcn ||
							seen.run_count !== want.run_count)
						log_miss("result mismatch", want, seen);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("ntfs_run_list_vcn_lookup verification failed");
			$finish;
		end
	end

	initial begin : run
		stim_t       dir_rows[$];
		logic [47:0] lo;
		logic [47:0] hi;
		logic [47:0] tgt;
		logic [7:0]  b;
		int          runs;
		int          cl;
		int          ol;
		int          n;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = 1'b0;
		s_tdata  = '0;
		idle_on  = 1'b1;

		// bytes straight after reset: dropped
		dir_rows.push_back(row(8'h21, 1'b0, '0, '0, '0, CHK_NONE, ST_FOUND, '0, '0));
		// target below low, then target at the top above high
		dir_rows.push_back(row(8'h21, 1'b1, 48'd5, 48'd10, 48'd20,
			CHK_TYPED, ST_RANGE, '0, '0));
		dir_rows.push_back(row(8'h21, 1'b1, VCN_MAX, '0, VCN_MAX - 48'd1,
			CHK_TYPED, ST_RANGE, '0, '0));
		// terminator as the very first byte
		dir_rows.push_back(row(8'h00, 1'b1, '0, '0, '0, CHK_TYPED, ST_END, '0, '0));
		// bytes after a result: dropped
		dir_rows.push_back(row(8'hff, 1'b0, VCN_MAX, VCN_MAX, VCN_MAX,
			CHK_NONE, ST_FOUND, '0, '0));
		// one run, two-byte positive delta
		dir_rows.push_back(row(8'h21, 1'b1, 48'd3, '0, VCN_MAX, CHK_MODEL, ST_FOUND, '0, '0));
		dir_rows.push_back(row(8'h08, 1'b0, '0, '0, '0, CHK_MODEL, ST_FOUND, '0, '0));
		dir_rows.push_back(row(8'h00, 1'b0, '0, '0, '0, CHK_MODEL, ST_FOUND, '0, '0));
		dir_rows.push_back(row(8'h01, 1'b0, '0, '0, '0, CHK_MODEL, ST_FOUND, '0, '0));
		// zero-length count moves only the LCN, then a negative delta
		dir_rows.push_back(row(8'h10, 1'b1, 48'd3, '0, VCN_MAX, CHK_MODEL, ST_FOUND, '0, '0));
		dir_rows.push_back(row(8'h64, 1'b0, '0, '0, '0, CHK_MODEL, ST_FOUND, '0, '0));
		dir_rows.push_back(row(8'h11, 1'b0, '0, '0, '0, CHK_MODEL, ST_FOUND, '0, '0));
		dir_rows.push_back(row(8'h0a, 1'b0, '0, '0, '0, CHK_MODEL, ST_FOUND, '0, '0));
		dir_rows.push_back(row(8'hf0, 1'b0, '0, '0, '0, CHK_MODEL, ST_FOUND, '0, '0));
		// sparse run with no delta bytes
		dir_rows.push_back(row(8'h01, 1'b1, 48'd2, '0, 48'd9, CHK_MODEL, ST_FOUND, '0, '0));
		dir_rows.push_back(row(8'h04, 1'b0, '0, '0, '0, CHK_MODEL, ST_FOUND, '0, '0));
		// new list in the middle of a run, ending at once on a terminator
		dir_rows.push_back(row(8'h31, 1'b1, '0, '0, VCN_MAX, CHK_MODEL, ST_FOUND, '0, '0));
		dir_rows.push_back(row(8'h00, 1'b1, VCN_MAX, VCN_MAX, VCN_MAX,
			CHK_TYPED, ST_END, '0, '0));
		// seven-byte count: the top byte falls off
		dir_rows.push_back(row(8'h07, 1'b1, '0, '0, VCN_MAX, CHK_MODEL, ST_FOUND, '0, '0));
		repeat (7)
			dir_rows.push_back(row(8'hff, 1'b0, '0, '0, '0, CHK_MODEL, ST_FOUND, '0, '0));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send(dir_rows[i]);

		// Random part: mostly well-formed lists with random content, some cut short,
		// some noise. Idling stops for the last stretch.
		while (list_words < RANDOM_WORDS) begin
			idle_on = (list_words < RANDOM_WORDS - 150) && ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4))
					send(row(8'($urandom), 1'($urandom_range(0, 1)), rand48(), rand48(),
						rand48(), CHK_MODEL, ST_FOUND, '0, '0));
			end else begin
				lo = rand48();
				if ($urandom_range(0, 7) == 0) begin
					tgt = rand48();
					hi  = rand48();
				end else begin
					// keep the target near the start so the runs reach it
					tgt = lo + 48'($urandom_range(0, 60));
					hi  = $urandom_range(0, 1) ? VCN_MAX : tgt + 48'($urandom_range(0, 1000));
				end
				runs = $urandom_range(1, 6);
				for (int r = 0; r < runs; r++) begin
					if ($urandom_range(0, 7) == 0) begin
						b = 8'($urandom);
					end else begin
						cl = field_len();
						ol = field_len();
						b  = {4'(ol), 4'(cl)};
					end
					cl = int'(b[3:0]);
					ol = int'(b[7:4]);
					send(row(b, r == 0, tgt, lo, hi, CHK_MODEL, ST_FOUND, '0, '0));
					list_words++;
					n = cl + ol;
					if ($urandom_range(0, 11) == 0)
						n = $urandom_range(0, n);
					for (int i = 0; i < n; i++) begin
						if (i == 0 && cl == 1 && $urandom_range(0, 1))
							b = 8'($urandom_range(0, 40));
						else
							b = 8'($urandom);
						send(row(b, 1'b0, rand48(), rand48(), rand48(),
							CHK_MODEL, ST_FOUND, '0, '0));
						list_words++;
					end
					// a run cut short: drop the rest of this list
					if (n < cl + ol)
						break;
				end
				if ($urandom_range(0, 3) != 0) begin
					send(row(8'h00, 1'b0, tgt, lo, hi, CHK_MODEL, ST_FOUND, '0, '0));
					list_words++;
				end
			end
		end

		// drain: wait for every due result, then allow for the pipeline
		idle_on = 1'b0;
		s_tvalid <= 1'b0;
		while (lookups_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (miss_count == 0)
			$display("ntfs_run_list_vcn_lookup verification clean");
		else
			$display("ntfs_run_list_vcn_lookup verification failed");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/nrl_pkg.sv
hw/rtl/nrl_decode.sv
hw/rtl/ntfs_run_list_vcn_lookup.sv
bench/tb_ntfs_run_list_vcn_lookup.sv
